// File: src/cdn_pkg.sv
package cdn_pkg;

	localparam int STEP_W = 4;
	localparam int YEAR_W = 11;
	localparam int DN_W   = 15;

	localparam logic [YEAR_W-1:0] FIRST_YEAR     = 11'd1970;
	localparam logic [YEAR_W-1:0] LAST_YEAR      = 11'd2038;
	localparam logic [DN_W-1:0]   MAX_DAY_NUMBER = 15'd25201;
	localparam logic [3:0]        LAST_MONTH     = 4'd12;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_WAIT      = 4'd0;
	localparam step_t ST_BRANCH    = 4'd1;
	localparam step_t ST_CHECK     = 4'd2;
	localparam step_t ST_ADD_YEAR  = 4'd3;
	localparam step_t ST_ADD_MONTH = 4'd4;
	localparam step_t ST_ADD_DAY   = 4'd5;
	localparam step_t ST_EMIT      = 4'd6;
	localparam step_t ST_RANGE     = 4'd7;
	localparam step_t ST_SUB_YEAR  = 4'd8;
	localparam step_t ST_SUB_MONTH = 4'd9;
	localparam step_t ST_SET_DAY   = 4'd10;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_SET_ERR,
		ACT_ADD_YEAR,
		ACT_ADD_MONTH,
		ACT_ADD_DAY,
		ACT_SUB_YEAR,
		ACT_SUB_MONTH,
		ACT_SET_DAY,
		ACT_EMIT
	} act_t;

	typedef enum logic [3:0] {
		COND_ALWAYS,
		COND_ACCEPT,
		COND_OP_D2Y,
		COND_BAD_DATE,
		COND_YR_LT,
		COND_MO_LT,
		COND_BAD_DN,
		COND_YEAR_FITS,
		COND_MONTH_FITS,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		cond_t cond;
		act_t  act;
		step_t target;
		step_t next;
	} uword_t;

	typedef struct packed {
		logic op_d2y;
		logic bad_date;
		logic yr_lt;
		logic mo_lt;
		logic bad_dn;
		logic year_fits;
		logic month_fits;
	} dp_flags_t;

	typedef struct packed {
		logic             status;
		logic [DN_W-1:0]  day_number;
		logic [YEAR_W-1:0] year;
		logic [3:0]       month;
		logic [4:0]       day;
	} result_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		case (s)
			ST_WAIT:      w = '{COND_ACCEPT,     ACT_LOAD,      ST_BRANCH,    ST_WAIT};
			ST_BRANCH:    w = '{COND_OP_D2Y,     ACT_NONE,      ST_RANGE,     ST_CHECK};
			ST_CHECK:     w = '{COND_BAD_DATE,   ACT_SET_ERR,   ST_EMIT,      ST_ADD_YEAR};
			ST_ADD_YEAR:  w = '{COND_YR_LT,      ACT_ADD_YEAR,  ST_ADD_YEAR,  ST_ADD_MONTH};
			ST_ADD_MONTH: w = '{COND_MO_LT,      ACT_ADD_MONTH, ST_ADD_MONTH, ST_ADD_DAY};
			ST_ADD_DAY:   w = '{COND_ALWAYS,     ACT_ADD_DAY,   ST_EMIT,      ST_EMIT};
			ST_EMIT:      w = '{COND_OUT_FREE,   ACT_EMIT,      ST_WAIT,      ST_EMIT};
			ST_RANGE:     w = '{COND_BAD_DN,     ACT_SET_ERR,   ST_EMIT,      ST_SUB_YEAR};
			ST_SUB_YEAR:  w = '{COND_YEAR_FITS,  ACT_SUB_YEAR,  ST_SUB_YEAR,  ST_SUB_MONTH};
			ST_SUB_MONTH: w = '{COND_MONTH_FITS, ACT_SUB_MONTH, ST_SUB_MONTH, ST_SET_DAY};
			ST_SET_DAY:   w = '{COND_ALWAYS,     ACT_SET_DAY,   ST_EMIT,      ST_EMIT};
			default:      w = '{COND_ALWAYS,     ACT_NONE,      ST_WAIT,      ST_WAIT};
		endcase
		return w;
	endfunction

	// valid for years 1970..2038 only, where every fourth year is leap
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'b00);
	endfunction

	function automatic logic [8:0] year_len(input logic [YEAR_W-1:0] y);
		return is_leap(y) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic [YEAR_W-1:0] y, input logic [3:0] m);
		logic [4:0] n;
		case (m) inside
			4'd2:                    n = is_leap(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default:                 n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

// File: src/cdn_datapath.sv
module cdn_datapath
	import cdn_pkg::*;
(
	input  logic              clk,
	input  act_t              act,
	input  logic              operation,
	input  logic [11:0]       year_in,
	input  logic [3:0]        month_in,
	input  logic [4:0]        day_in,
	input  logic [DN_W-1:0]   day_number_in,
	output dp_flags_t         flags,
	output result_t           result
);

	logic              op_q;
	logic              err_q;
	logic [11:0]       tyear_q;
	logic [3:0]        tmon_q;
	logic [4:0]        day_q;
	logic [YEAR_W-1:0] yr_q;
	logic [3:0]        mo_q;
	logic [DN_W-1:0]   acc_q;

	logic [DN_W-1:0] ylen;
	logic [DN_W-1:0] mlen;

	assign ylen = {6'd0, year_len(yr_q)};
	assign mlen = {10'd0, month_len(yr_q, mo_q)};

	always_comb begin
		flags.op_d2y     = op_q;
		flags.bad_date   = (tyear_q < {1'b0, FIRST_YEAR}) || (tyear_q > {1'b0, LAST_YEAR}) ||
		                   (tmon_q == 4'd0) || (tmon_q > LAST_MONTH) || (day_q == 5'd0) ||
		                   (day_q > month_len(tyear_q[YEAR_W-1:0], tmon_q));
		flags.yr_lt      = ({1'b0, yr_q} < tyear_q);
		flags.mo_lt      = (mo_q < tmon_q);
		flags.bad_dn     = (acc_q > MAX_DAY_NUMBER);
		flags.year_fits  = (yr_q < LAST_YEAR) && (acc_q >= ylen);
		flags.month_fits = (mo_q < LAST_MONTH) && (acc_q >= mlen);
	end

	always_ff @(posedge clk) begin
		case (act)
			ACT_LOAD: begin
				op_q    <= operation;
				err_q   <= 1'b0;
				tyear_q <= year_in;
				tmon_q  <= month_in;
				day_q   <= day_in;
				yr_q    <= FIRST_YEAR;
				mo_q    <= 4'd1;
				acc_q   <= operation ? day_number_in : '0;
			end
			ACT_SET_ERR: begin
				err_q <= 1'b1;
			end
			ACT_ADD_YEAR: begin
				acc_q <= acc_q + ylen;
				yr_q  <= yr_q + 11'd1;
			end
			ACT_ADD_MONTH: begin
				acc_q <= acc_q + mlen;
				mo_q  <= mo_q + 4'd1;
			end
			ACT_ADD_DAY: begin
				acc_q <= acc_q + {10'd0, day_q} - 15'd1;
			end
			ACT_SUB_YEAR: begin
				acc_q <= acc_q - ylen;
				yr_q  <= yr_q + 11'd1;
			end
			ACT_SUB_MONTH: begin
				acc_q <= acc_q - mlen;
				mo_q  <= mo_q + 4'd1;
			end
			ACT_SET_DAY: begin
				day_q <= acc_q[4:0] + 5'd1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.status     = err_q;
		result.day_number = (!err_q && !op_q) ? acc_q : '0;
		result.year       = (!err_q && op_q) ? yr_q : FIRST_YEAR;
		result.month      = (!err_q && op_q) ? mo_q : 4'd1;
		result.day        = (!err_q && op_q) ? day_q : 5'd1;
	end

endmodule

// File: src/cdn_sequencer.sv
module cdn_sequencer
	import cdn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic      out_free,
	input  dp_flags_t flags,
	output act_t      act,
	output step_t     step
);

	step_t  step_q;
	uword_t uw;
	logic   hit;

	assign uw   = ucode(step_q);
	assign step = step_q;

	always_comb begin
		case (uw.cond)
			COND_ALWAYS:     hit = 1'b1;
			COND_ACCEPT:     hit = accept;
			COND_OP_D2Y:     hit = flags.op_d2y;
			COND_BAD_DATE:   hit = flags.bad_date;
			COND_YR_LT:      hit = flags.yr_lt;
			COND_MO_LT:      hit = flags.mo_lt;
			COND_BAD_DN:     hit = flags.bad_dn;
			COND_YEAR_FITS:  hit = flags.year_fits;
			COND_MONTH_FITS: hit = flags.month_fits;
			COND_OUT_FREE:   hit = out_free;
			default:         hit = 1'b0;
		endcase
	end

	assign act = hit ? uw.act : ACT_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= hit ? uw.target : uw.next;
		end
	end

endmodule

// File: src/calendar_day_number_converter_core.sv
// channel   | direction | signals                      | contents
// s_axis    | in        | tvalid tready tdata tuser    | date or day number to convert
// m_axis    | out       | tvalid tready tdata tuser    | converted result with status
// The microcode loop that forms each result steps one year per cycle (up to 68)
// and one month per cycle (up to 11).
// A new item is taken only when the sequencer is back at its wait step.
// The result register holds while m_axis_tready is low; the next item is
// accepted meanwhile and its result waits at the emit step.
// arst_n returns the sequencer to its wait step and empties the result register.
module calendar_day_number_converter_core
	import cdn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // year_in[11:0], month_in[15:12], day_in[20:16],
	                                   // day_number_in[35:21], zero[39:36]
	input  logic        s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // day_number_out[14:0], year_out[25:15],
	                                   // month_out[29:26], day_out[34:30], zero[39:35]
	output logic        m_axis_tuser   // status
);

	act_t      act;
	step_t     step;
	dp_flags_t flags;
	result_t   result;
	result_t   out_q;
	logic      m_valid_q;
	logic      accept;
	logic      out_free;

	assign s_axis_tready = (step == ST_WAIT);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	cdn_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.out_free (out_free),
		.flags    (flags),
		.act      (act),
		.step     (step)
	);

	cdn_datapath u_dp (
		.clk           (clk),
		.act           (act),
		.operation     (s_axis_tuser),
		.year_in       (s_axis_tdata[11:0]),
		.month_in      (s_axis_tdata[15:12]),
		.day_in        (s_axis_tdata[20:16]),
		.day_number_in (s_axis_tdata[35:21]),
		.flags         (flags),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (act == ACT_EMIT) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act == ACT_EMIT) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {5'd0, out_q.day, out_q.month, out_q.year, out_q.day_number};

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
	import cdn_pkg::*;

	localparam logic OP_TO_DAY_NUMBER = 1'b0;
	localparam logic OP_TO_DATE       = 1'b1;
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_INVALID   = 1'b1;

	localparam int N_DIRECTED     = 25;
	localparam int N_RANDOM       = 1125;
	localparam int N_CALM_TAIL    = 150;
	localparam int DRAIN_AT       = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 100;

	typedef struct packed {
		logic              status;
		logic [DN_W-1:0]   day_number;
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
	} date_result_t;

	typedef struct packed {
		logic         op;
		logic [11:0]  year;
		logic [3:0]   month;
		logic [4:0]   day;
		logic [14:0]  day_number;
		logic         typed;
		date_result_t want;
	} stim_row_t;

	localparam date_result_t EPOCH_DATE = '{STATUS_OK, 15'd0, FIRST_YEAR, 4'd1, 5'd1};
	localparam date_result_t REJECTED   = '{STATUS_INVALID, 15'd0, FIRST_YEAR, 4'd1, 5'd1};
	localparam date_result_t LAST_AS_DN = '{STATUS_OK, MAX_DAY_NUMBER, FIRST_YEAR, 4'd1, 5'd1};
	localparam date_result_t LAST_DATE  = '{STATUS_OK, 15'd0, LAST_YEAR, 4'd12, 5'd31};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;

	logic         row_typed = 1'b0;
	date_result_t row_want = '0;
	logic         calm_tail = 1'b0;

	date_result_t expected_dates[$];
	int           fail_count = 0;
	int           idle_cycles = 0;
	int           sink_hold = 0;
	int           sink_stall_pct = 0;
	int           sink_phase = 0;
	int           n_to_number = 0;
	int           n_to_date = 0;
	int           n_checked = 0;
	int           n_invalid = 0;

	calendar_day_number_converter_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned year_days(input int unsigned y);
		return leap_year(y) ? 366 : 365;
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		int unsigned n;
		case (m)
			2:           n = leap_year(y) ? 29 : 28;
			4, 6, 9, 11: n = 30;
			default:     n = 31;
		endcase
		return n;
	endfunction

	function automatic date_result_t convert_item(input logic op, input logic [11:0] yr,
			input logic [3:0] mo, input logic [4:0] dy, input logic [14:0] num);
		date_result_t r;
		int unsigned  total;
		int unsigned  rest;
		int unsigned  y;
		int unsigned  m;
		r = EPOCH_DATE;
		if (op == OP_TO_DAY_NUMBER) begin
			if (yr < FIRST_YEAR || yr > LAST_YEAR || mo < 1 || mo > 12 || dy < 1 ||
					dy > month_days(yr, mo)) begin
				r.status = STATUS_INVALID;
			end else begin
				total = 0;
				for (y = FIRST_YEAR; y < yr; y++)
					total += year_days(y);
				for (m = 1; m < mo; m++)
					total += month_days(yr, m);
				r.day_number = DN_W'(total + dy - 1);
			end
		end else if (num > MAX_DAY_NUMBER) begin
			r.status = STATUS_INVALID;
		end else begin
			rest = 32'(num);
			y = FIRST_YEAR;
			m = 1;
			while (y < LAST_YEAR && rest >= year_days(y)) begin
				rest -= year_days(y);
				y++;
			end
			while (m < 12 && rest >= month_days(y, m)) begin
				rest -= month_days(y, m);
				m++;
			end
			r.year = YEAR_W'(y);
			r.month = 4'(m);
			r.day = 5'(rest + 1);
		end
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		date_result_t got;
		date_result_t want;
		logic         moved;
		moved = 1'b0;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			moved = 1'b1;
			if (s_axis_tuser == OP_TO_DAY_NUMBER)
				n_to_number++;
			else
				n_to_date++;
			if (row_typed)
				expected_dates.push_back(row_want);
			else
				expected_dates.push_back(convert_item(s_axis_tuser, s_axis_tdata[11:0],
					s_axis_tdata[15:12], s_axis_tdata[20:16], s_axis_tdata[35:21]));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			moved = 1'b1;
			got = '{m_axis_tuser, m_axis_tdata[14:0], m_axis_tdata[25:15],
				m_axis_tdata[29:26], m_axis_tdata[34:30]};
			if (expected_dates.size() == 0) begin
				$error("result with nothing expected: tdata %h status %0d", m_axis_tdata,
					m_axis_tuser);
				fail_count++;
			end else begin
				want = expected_dates.pop_front();
				n_checked++;
				if (got.status == STATUS_INVALID)
					n_invalid++;
				if (got.status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					fail_count++;
				end
				if (got.day_number != want.day_number) begin
					$error("day_number_out: expected %0d, got %0d", want.day_number,
						got.day_number);
					fail_count++;
				end
				if (got.year != want.year) begin
					$error("year_out: expected %0d, got %0d", want.year, got.year);
					fail_count++;
				end
				if (got.month != want.month) begin
					$error("month_out: expected %0d, got %0d", want.month, got.month);
					fail_count++;
				end
				if (got.day != want.day) begin
					$error("day_out: expected %0d, got %0d", want.day, got.day);
					fail_count++;
				end
			end
		end
		idle_cycles <= moved ? 0 : idle_cycles + 1;
	end

	always @(posedge clk) begin
		sink_phase <= sink_phase + 1;
		if (sink_phase % 128 == 0) begin
			case ($urandom_range(0, 2))
				0:       sink_stall_pct <= 0;
				1:       sink_stall_pct <= 15;
				default: sink_stall_pct <= 50;
			endcase
		end
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else if (!calm_tail && $urandom_range(0, 99) < sink_stall_pct) begin
			m_axis_tready <= 1'b0;
			sink_hold <= $urandom_range(0, 8);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_item(input logic op, input logic [11:0] yr, input logic [3:0] mo,
			input logic [4:0] dy, input logic [14:0] num, input logic typed,
			input date_result_t want);
		s_axis_tuser <= op;
		s_axis_tdata <= {4'd0, num, dy, mo, yr};
		row_typed <= typed;
		row_want <= want;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic maybe_pause(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	initial begin
		stim_row_t    directed_rows [N_DIRECTED];
		int           source_gap_pct;
		int           kind;
		logic         op;
		logic [11:0]  yr;
		logic [3:0]   mo;
		logic [4:0]   dy;
		logic [14:0]  num;

		directed_rows = '{
			'{OP_TO_DAY_NUMBER, 12'd1970, 4'd1,  5'd1,  15'd0,     1'b1, EPOCH_DATE},
			'{OP_TO_DAY_NUMBER, 12'd2038, 4'd12, 5'd31, 15'd0,     1'b1, LAST_AS_DN},
			'{OP_TO_DAY_NUMBER, 12'd0,    4'd0,  5'd0,  15'd0,     1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd4095, 4'd15, 5'd31, 15'd32767, 1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd1969, 4'd12, 5'd31, 15'd0,     1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd2039, 4'd1,  5'd1,  15'd0,     1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd1970, 4'd0,  5'd1,  15'd0,     1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd1970, 4'd13, 5'd1,  15'd0,     1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd1970, 4'd1,  5'd0,  15'd0,     1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd1970, 4'd4,  5'd31, 15'd0,     1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd1971, 4'd2,  5'd29, 15'd0,     1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd1972, 4'd2,  5'd29, 15'd0,     1'b0, '0},
			'{OP_TO_DAY_NUMBER, 12'd1972, 4'd2,  5'd30, 15'd0,     1'b1, REJECTED},
			'{OP_TO_DAY_NUMBER, 12'd2000, 4'd2,  5'd29, 15'd0,     1'b0, '0},
			'{OP_TO_DAY_NUMBER, 12'd2036, 4'd12, 5'd31, 15'd0,     1'b0, '0},
			'{OP_TO_DATE,       12'd4095, 4'd15, 5'd31, 15'd0,     1'b1, EPOCH_DATE},
			'{OP_TO_DATE,       12'd0,    4'd0,  5'd0,  15'd25201, 1'b1, LAST_DATE},
			'{OP_TO_DATE,       12'd0,    4'd0,  5'd0,  15'd25202, 1'b1, REJECTED},
			'{OP_TO_DATE,       12'd0,    4'd0,  5'd0,  15'd32767, 1'b1, REJECTED},
			'{OP_TO_DATE,       12'd0,    4'd0,  5'd0,  15'd789,   1'b0, '0},
			'{OP_TO_DATE,       12'd0,    4'd0,  5'd0,  15'd790,   1'b0, '0},
			'{OP_TO_DATE,       12'd0,    4'd0,  5'd0,  15'd10957, 1'b0, '0},
			'{OP_TO_DATE,       12'd0,    4'd0,  5'd0,  15'd11016, 1'b0, '0},
			'{OP_TO_DATE,       12'd0,    4'd0,  5'd0,  15'd364,   1'b0, '0},
			'{OP_TO_DATE,       12'd0,    4'd0,  5'd0,  15'd365,   1'b0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].op, directed_rows[i].year, directed_rows[i].month,
				directed_rows[i].day, directed_rows[i].day_number, directed_rows[i].typed,
				directed_rows[i].want);
			maybe_pause(30);
		end

		source_gap_pct = 20;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 64 == 0 && i < N_RANDOM - N_CALM_TAIL) begin
				case ($urandom_range(0, 2))
					0:       source_gap_pct = 0;
					1:       source_gap_pct = 15;
					default: source_gap_pct = 50;
				endcase
			end
			if (i == N_RANDOM - N_CALM_TAIL) begin
				calm_tail <= 1'b1;
				source_gap_pct = 0;
			end
			if (i == DRAIN_AT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (expected_dates.size() != 0)
					@(posedge clk);
			end

			yr = 12'($urandom_range(0, 4095));
			mo = 4'($urandom_range(0, 15));
			dy = 5'($urandom_range(0, 31));
			num = 15'($urandom_range(0, 32767));
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				op = OP_TO_DAY_NUMBER;
				yr = 12'($urandom_range(FIRST_YEAR, LAST_YEAR));
				mo = 4'($urandom_range(1, 12));
				dy = 5'($urandom_range(1, month_days(yr, mo)));
			end else if (kind < 55) begin
				op = OP_TO_DAY_NUMBER;
				yr = 12'($urandom_range(FIRST_YEAR - 5, LAST_YEAR + 5));
			end else if (kind < 65) begin
				op = OP_TO_DAY_NUMBER;
			end else if (kind < 92) begin
				op = OP_TO_DATE;
				num = 15'($urandom_range(0, MAX_DAY_NUMBER));
			end else begin
				op = OP_TO_DATE;
			end
			send_item(op, yr, mo, dy, num, 1'b0, '0);
			maybe_pause(source_gap_pct);
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("converted %0d dates to day numbers and %0d day numbers to dates",
			n_to_number, n_to_date);
		$display("compared %0d results, %0d of them flagged invalid", n_checked, n_invalid);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
